@@ rtl/qrs_pkg.sv @@
// Quadratic root solver: shared widths, root kind codes and pipeline item types.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
package qrs_pkg;
    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = 40;

    localparam int CW     = COEF_WIDTH;
    localparam int PROD_W = 2 * CW;
    localparam int DISC_W = 2 * CW + 2;
    localparam int MAG_W  = 2 * CW + 1;
    localparam int SQRT_W = (MAG_W + 1) / 2;
    localparam int RAD_W  = 2 * SQRT_W;
    localparam int SREM_W = SQRT_W + 2;
    localparam int NUM_W  = ((CW > SQRT_W) ? CW : SQRT_W) + 1;
    localparam int NS_W   = NUM_W + FRAC_BITS;
    localparam int DEN_W  = CW + 1;
    localparam int SAT_W  = ((NS_W > OUT_W) ? NS_W : OUT_W) + 1;
    localparam int LANES  = 3;

    typedef enum logic [1:0] {
        KIND_DISTINCT   = 2'd0,
        KIND_EQUAL      = 2'd1,
        KIND_COMPLEX    = 2'd2,
        KIND_DEGENERATE = 2'd3
    } t_kind;

    typedef struct packed {
        logic                     valid;
        t_kind                    kind;
        logic signed [CW-1:0]     a;
        logic signed [CW-1:0]     b;
        logic [RAD_W-1:0]         rad;
        logic [SREM_W-1:0]        rem;
        logic [SQRT_W-1:0]        root;
    } t_sq_item;

    typedef struct packed {
        logic [NS_W-1:0]  num;
        logic [DEN_W-1:0] rem;
        logic [NS_W-1:0]  quo;
        logic             neg;
    } t_dv_lane;

    typedef struct packed {
        logic                 valid;
        t_kind                kind;
        logic [DEN_W-1:0]     den;
        t_dv_lane [LANES-1:0] lane;
    } t_dv_item;
endpackage

@@ rtl/qrs_if.sv @@
// Request and result channel interfaces for the quadratic root solver.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
interface qrs_in_if import qrs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;

    modport source(output valid, coef_a, coef_b, coef_c, input ready);
    modport sink(input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if import qrs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              root_kind;
    logic signed [OUT_W-1:0] first_real;
    logic signed [OUT_W-1:0] second_real;
    logic signed [OUT_W-1:0] imag_part;

    modport source(output valid, root_kind, first_real, second_real, imag_part, input ready);
    modport sink(input valid, root_kind, first_real, second_real, imag_part, output ready);
endinterface

@@ rtl/qrs_front.sv @@
// Front end: coefficient products, discriminant and root kind.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_front import qrs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_a,
    input  logic signed [CW-1:0] i_b,
    input  logic signed [CW-1:0] i_c,
    output t_sq_item             o_item
);
    logic                     r_valid;
    logic signed [CW-1:0]     r_a;
    logic signed [CW-1:0]     r_b;
    logic signed [PROD_W-1:0] r_bb;
    logic signed [PROD_W-1:0] r_ac;
    logic signed [DISC_W-1:0] w_disc;
    t_sq_item                 n_item;
    t_sq_item                 r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_bb <= PROD_W'(i_b) * PROD_W'(i_b);
            r_ac <= PROD_W'(i_a) * PROD_W'(i_c);
        end
    end

    assign w_disc = DISC_W'(r_bb) - (DISC_W'(r_ac) <<< 2);

    always_comb begin
        logic [DISC_W-1:0] mag;
        mag          = w_disc[DISC_W-1] ? DISC_W'(-w_disc) : DISC_W'(w_disc);
        n_item       = '0;
        n_item.valid = r_valid;
        n_item.a     = r_a;
        n_item.b     = r_b;
        n_item.rad   = RAD_W'(mag[MAG_W-1:0]);
        if (r_a == '0) begin
            n_item.kind = KIND_DEGENERATE;
        end else if (w_disc[DISC_W-1]) begin
            n_item.kind = KIND_COMPLEX;
        end else if (w_disc == '0) begin
            n_item.kind = KIND_EQUAL;
        end else begin
            n_item.kind = KIND_DISTINCT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

@@ rtl/qrs_sqrt_cell.sv @@
// Square root cell: settles one root bit per stage from two radicand bits.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_sqrt_cell import qrs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_sq_item i_item,
    output t_sq_item o_item
);
    t_sq_item n_item;
    t_sq_item r_item;

    always_comb begin
        logic [SREM_W-1:0] shifted;
        logic [SREM_W-1:0] trial;
        shifted    = {i_item.rem[SQRT_W-1:0], i_item.rad[RAD_W-1 -: 2]};
        trial      = {i_item.root, 2'b01};
        n_item     = i_item;
        n_item.rad = i_item.rad << 2;
        if (shifted >= trial) begin
            n_item.rem  = shifted - trial;
            n_item.root = {i_item.root[SQRT_W-2:0], 1'b1};
        end else begin
            n_item.rem  = shifted;
            n_item.root = {i_item.root[SQRT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

@@ rtl/qrs_div_cell.sv @@
// Divider cell: settles one quotient bit per stage for all three root lanes.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_div_cell import qrs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_dv_item i_item,
    output t_dv_item o_item
);
    t_dv_item n_item;
    t_dv_item r_item;

    always_comb begin
        logic [DEN_W:0] shifted;
        logic [DEN_W:0] diff;
        n_item = i_item;
        for (int k = 0; k < LANES; k++) begin
            shifted = {i_item.lane[k].rem, i_item.lane[k].num[NS_W-1]};
            diff    = shifted - {1'b0, i_item.den};
            n_item.lane[k].num = i_item.lane[k].num << 1;
            if (shifted >= {1'b0, i_item.den}) begin
                n_item.lane[k].rem = diff[DEN_W-1:0];
                n_item.lane[k].quo = {i_item.lane[k].quo[NS_W-2:0], 1'b1};
            end else begin
                n_item.lane[k].rem = shifted[DEN_W-1:0];
                n_item.lane[k].quo = {i_item.lane[k].quo[NS_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

@@ rtl/quadratic_root_solver_top.sv @@
// Quadratic root solver top: front end, square root cell row, divider cell row, output stage.
// Depends on qrs_pkg, qrs_if, qrs_front, qrs_sqrt_cell, qrs_div_cell.
//
//   channel  dir  fields
//   i_in     in   coef_a, coef_b, coef_c (signed)
//   o_out    out  root_kind, first_real, second_real, imag_part (signed fixed point)
//
// One request per cycle while the output is not stalled. Each request passes the front end,
// one square root cell per root bit, the divider input register, one divider cell per quotient bit
// and the output register. Reset clears all stage valid bits. A stalled output freezes the whole pipe.
`timescale 1ns / 1ps
module quadratic_root_solver_top import qrs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    qrs_in_if.sink    i_in,
    qrs_out_if.source o_out
);
    localparam logic [SAT_W-1:0] POS_LIM = (SAT_W'(1) << (OUT_W - 1)) - SAT_W'(1);
    localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(1) << (OUT_W - 1);

    logic     w_adv;
    t_sq_item w_sq [SQRT_W+1];
    t_dv_item w_dv [NS_W+1];
    t_dv_item n_dv;
    t_dv_item r_dv;

    logic                    r_out_valid;
    logic [1:0]              r_kind;
    logic signed [OUT_W-1:0] r_res [LANES];

    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_in.valid),
        .i_a     (i_in.coef_a),
        .i_b     (i_in.coef_b),
        .i_c     (i_in.coef_c),
        .o_item  (w_sq[0])
    );

    for (genvar g = 0; g < SQRT_W; g++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_item  (w_sq[g]),
            .o_item  (w_sq[g+1])
        );
    end

    always_comb begin
        logic signed [NUM_W:0]  nb;
        logic signed [NUM_W:0]  ns;
        logic signed [NUM_W:0]  num [LANES];
        logic [NUM_W:0]         mag;
        logic [CW-1:0]          absa;
        t_sq_item               it;
        it   = w_sq[SQRT_W];
        nb   = -(NUM_W + 1)'(it.b);
        ns   = (NUM_W + 1)'({1'b0, it.root});
        absa = it.a[CW-1] ? CW'(-it.a) : CW'(it.a);
        if (it.kind == KIND_COMPLEX) begin
            num[0] = nb;
            num[1] = nb;
            num[2] = ns;
        end else begin
            num[0] = nb + ns;
            num[1] = nb - ns;
            num[2] = '0;
        end
        n_dv       = '0;
        n_dv.valid = it.valid;
        n_dv.kind  = it.kind;
        n_dv.den   = {absa, 1'b0};
        for (int k = 0; k < LANES; k++) begin
            mag = num[k][NUM_W] ? (NUM_W + 1)'(-num[k]) : (NUM_W + 1)'(num[k]);
            n_dv.lane[k].num = NS_W'(mag[NUM_W-1:0]) << FRAC_BITS;
            n_dv.lane[k].neg = num[k][NUM_W] ^ it.a[CW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv.valid <= 1'b0;
        end else if (w_adv) begin
            r_dv <= n_dv;
        end
    end

    assign w_dv[0] = r_dv;

    for (genvar g = 0; g < NS_W; g++) begin : g_div
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_item  (w_dv[g]),
            .o_item  (w_dv[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        logic [SAT_W-1:0] m;
        logic [SAT_W-1:0] v;
        t_dv_item         it;
        it = w_dv[NS_W];
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= it.valid;
        end
        if (w_adv) begin
            r_kind <= it.kind;
            for (int k = 0; k < LANES; k++) begin
                m = SAT_W'(it.lane[k].quo);
                if (it.lane[k].neg) begin
                    v = (m > NEG_LIM) ? -NEG_LIM : -m;
                end else begin
                    v = (m > POS_LIM) ? POS_LIM : m;
                end
                if (it.kind == KIND_DEGENERATE) begin
                    v = '0;
                end
                r_res[k] <= v[OUT_W-1:0];
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.root_kind   = r_kind;
    assign o_out.first_real  = r_res[0];
    assign o_out.second_real = r_res[1];
    assign o_out.imag_part   = r_res[2];
endmodule
